// ===== src/kat_pkg.sv =====
// shared types and constants of the kalbach angular table
`default_nettype none
package kat_pkg;

  // ln 2 in q27 and floor(2^40 / ln2_q27) for the range reduction
  localparam logic [26:0] Ln2Q27   = 27'd93032640;
  localparam logic [13:0] Ln2Recip = 14'd11818;

  // one in q32, one half in q16, one in q15
  localparam logic [32:0] OneQ32  = 33'h1_0000_0000;
  localparam logic [15:0] HalfQ16 = 16'h8000;
  localparam logic [15:0] OneQ15  = 16'h8000;

  // widths and pipeline depths
  localparam int unsigned ProbW  = 21;
  localparam int unsigned ExpLat = 26;
  localparam int unsigned DivLat = ProbW + 1;

  // configuration derived from sample_count
  typedef struct packed {
    logic [6:0]  cnt;
    logic [16:0] step;
    logic [6:0]  frac;
  } kat_cfg_t;

  // one accepted item after classification
  typedef struct packed {
    logic [15:0] slope;
    logic [15:0] fraction;
    logic        zero;
  } kat_desc_t;

  // one cosine point travelling down the back end
  typedef struct packed {
    logic        vld;
    logic [6:0]  idx;
    logic [15:0] mu;
    logic        last;
    logic [15:0] slope;
    logic [15:0] fraction;
    logic        zero;
  } kat_point_t;

endpackage
`default_nettype wire

// ===== src/kat_exp.sv =====
// pipelined e^(-t) for t in q27, result in q32
`default_nettype none
module kat_exp (
  input  logic        clk_i,
  input  logic [31:0] t_i,
  output logic [32:0] e_o
);
  import kat_pkg::*;

  localparam int unsigned NumK = 11;

  logic [31:0] t1_q;
  logic [45:0] pr_q;
  logic [5:0]  qe;
  logic [32:0] ql;
  logic [31:0] f0_full;
  logic [27:0] f0_q;
  logic [5:0]  q2_q;
  logic        ge;
  logic [27:0] fr;

  logic [31:0]        term_q [NumK+1];
  logic [31:0]        f32_q  [NumK+1];
  logic [5:0]         n_q    [NumK+1];
  logic signed [35:0] sum_q  [NumK+1];
  logic [31:0]        pa_q   [NumK];
  logic [31:0]        fa_q   [NumK];
  logic [5:0]         na_q   [NumK];
  logic signed [35:0] sa_q   [NumK];

  logic signed [35:0] sf;
  logic [32:0]        cl;
  logic [32:0]        e_q;

  // range reduction: estimate n by reciprocal multiply
  always_ff @(posedge clk_i) begin
    t1_q <= t_i;
    pr_q <= 46'(t_i) * 46'(Ln2Recip);
  end

  assign qe      = pr_q[45:40];
  assign ql      = 33'(qe) * 33'(Ln2Q27);
  assign f0_full = t1_q - ql[31:0];

  always_ff @(posedge clk_i) begin
    f0_q <= f0_full[27:0];
    q2_q <= qe;
  end

  // correct the estimate by one, start the series
  assign ge = f0_q >= {1'b0, Ln2Q27};
  assign fr = ge ? (f0_q - {1'b0, Ln2Q27}) : f0_q;

  always_ff @(posedge clk_i) begin
    f32_q[0]  <= {fr[26:0], 5'b0};
    term_q[0] <= {fr[26:0], 5'b0};
    n_q[0]    <= q2_q + 6'(ge);
    sum_q[0]  <= $signed({3'b0, OneQ32}) - $signed({4'b0, fr[26:0], 5'b0});
  end

  // series terms two to twelve, two stages each
  for (genvar j = 0; j < NumK; j++) begin : g_term
    localparam int unsigned Kv    = j + 2;
    localparam logic [63:0] MkW   = ((64'd1 << 36) + 64'(Kv) - 64'd1) / 64'(Kv);
    localparam logic [35:0] Mk    = MkW[35:0];
    logic [63:0] prod;
    logic [67:0] qdiv;
    logic [31:0] term;

    assign prod = 64'(term_q[j]) * 64'(f32_q[j]);
    always_ff @(posedge clk_i) begin
      pa_q[j] <= prod[63:32];
      fa_q[j] <= f32_q[j];
      na_q[j] <= n_q[j];
      sa_q[j] <= sum_q[j];
    end

    // exact division by the small constant k
    assign qdiv = 68'(pa_q[j]) * 68'(Mk);
    assign term = qdiv[67:36];
    always_ff @(posedge clk_i) begin
      term_q[j+1] <= term;
      f32_q[j+1]  <= fa_q[j];
      n_q[j+1]    <= na_q[j];
      if ((Kv % 2) == 1) begin
        sum_q[j+1] <= sa_q[j] - $signed({4'b0, term});
      end else begin
        sum_q[j+1] <= sa_q[j] + $signed({4'b0, term});
      end
    end
  end

  // clamp to [0, 1] and scale by 2^-n
  assign sf = sum_q[NumK];
  always_comb begin
    if (sf < 0) begin
      cl = '0;
    end else if (sf > $signed({3'b0, OneQ32})) begin
      cl = OneQ32;
    end else begin
      cl = sf[32:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_q[NumK] >= 6'd34) begin
      e_q <= '0;
    end else begin
      e_q <= cl >> n_q[NumK];
    end
  end

  assign e_o = e_q;

endmodule
`default_nettype wire

// ===== src/kat_pdiv.sv =====
// pipelined restoring divider, one quotient bit per stage, saturating
`default_nettype none
module kat_pdiv (
  input  logic                      clk_i,
  input  logic [52:0]               x_i,
  input  logic [32:0]               d_i,
  output logic [kat_pkg::ProbW-1:0] q_o
);
  import kat_pkg::*;

  localparam int unsigned QW = ProbW;

  logic [53:0]   rem_q [QW+1];
  logic [32:0]   dv_q  [QW+1];
  logic [QW-1:0] q_q   [QW+1];
  logic          sat_q [QW+1];

  // overflow check against d * 2^QW
  always_ff @(posedge clk_i) begin
    rem_q[0] <= {1'b0, x_i};
    dv_q[0]  <= d_i;
    q_q[0]   <= '0;
    sat_q[0] <= {1'b0, x_i} >= ({21'b0, d_i} << QW);
  end

  // one quotient bit per stage, msb first
  for (genvar s = 1; s <= QW; s++) begin : g_stage
    localparam int unsigned B = QW - s;
    logic [53:0] sh;
    logic        ge;

    assign sh = {21'b0, dv_q[s-1]} << B;
    assign ge = rem_q[s-1] >= sh;
    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? (rem_q[s-1] - sh) : rem_q[s-1];
      dv_q[s]  <= dv_q[s-1];
      q_q[s]   <= q_q[s-1] | (QW'(ge) << B);
      sat_q[s] <= sat_q[s-1];
    end
  end

  assign q_o = sat_q[QW] ? '1 : q_q[QW];

endmodule
`default_nettype wire

// ===== src/kat_front.sv =====
// front end: configuration, item accept, classification and item queue
`default_nettype none
module kat_front #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [15:0]        slope_param_i,
  input  logic [15:0]        fraction_param_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [6:0]         cfg_data_i,
  output kat_pkg::kat_cfg_t  cfg_o,
  output kat_pkg::kat_desc_t desc_o,
  output logic               desc_valid_o,
  input  logic               desc_pop_i
);
  import kat_pkg::*;

  localparam logic [6:0] MaxCnt = (MAX_SAMPLES > 127) ? 7'd127 : 7'(MAX_SAMPLES);

  logic [6:0]  cnt_q;
  logic [16:0] step_q;
  logic [6:0]  frac_q;
  logic        div_busy_q;
  logic [4:0]  div_cnt_q;
  logic [16:0] dvd_q;
  logic [6:0]  rem_q;
  logic [6:0]  wr_cnt;
  logic        cfg_wr;
  logic [7:0]  rem_sh;
  logic        dge;
  logic [7:0]  rem_d;
  logic [16:0] dvd_d;

  kat_desc_t   fifo_q [2];
  kat_desc_t   new_desc;
  logic        wptr_q;
  logic        rptr_q;
  logic [1:0]  fcnt_q;
  logic        push;

  // clamp the written count to 1..max
  always_comb begin
    if (cfg_data_i == 7'd0) begin
      wr_cnt = 7'd1;
    end else if (cfg_data_i > MaxCnt) begin
      wr_cnt = MaxCnt;
    end else begin
      wr_cnt = cfg_data_i;
    end
  end

  assign cfg_ready_o = !div_busy_q;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // serial divide 65536 / count for the cosine step
  assign rem_sh = {rem_q, dvd_q[16]};
  assign dge    = rem_sh >= {1'b0, cnt_q};
  assign rem_d  = dge ? (rem_sh - {1'b0, cnt_q}) : rem_sh;
  assign dvd_d  = {dvd_q[15:0], dge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= 7'd32;
      step_q     <= 17'd2048;
      frac_q     <= '0;
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
      dvd_q      <= '0;
      rem_q      <= '0;
    end else if (cfg_wr) begin
      cnt_q      <= wr_cnt;
      div_busy_q <= 1'b1;
      div_cnt_q  <= '0;
      dvd_q      <= 17'h1_0000;
      rem_q      <= '0;
    end else if (div_busy_q) begin
      dvd_q     <= dvd_d;
      rem_q     <= rem_d[6:0];
      div_cnt_q <= div_cnt_q + 5'd1;
      if (div_cnt_q == 5'd16) begin
        div_busy_q <= 1'b0;
        step_q     <= dvd_d;
        frac_q     <= rem_d[6:0];
      end
    end
  end

  assign cfg_o.cnt  = cnt_q;
  assign cfg_o.step = step_q;
  assign cfg_o.frac = frac_q;

  // classify: saturate the fraction, flag a zero slope
  assign new_desc.slope    = slope_param_i;
  assign new_desc.fraction = (fraction_param_i > OneQ15) ? OneQ15 : fraction_param_i;
  assign new_desc.zero     = slope_param_i == 16'd0;

  assign busy_o = (fcnt_q == 2'd2) || div_busy_q;
  assign push   = start_i && !busy_o;

  // two-entry item queue
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= new_desc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fcnt_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (desc_pop_i) begin
        rptr_q <= !rptr_q;
      end
      fcnt_q <= fcnt_q + 2'(push) - 2'(desc_pop_i);
    end
  end

  assign desc_o       = fifo_q[rptr_q];
  assign desc_valid_o = fcnt_q != 2'd0;

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q != 2'd3) else $error("item queue count out of range");

  a_no_accept_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy_q |-> !push) else $error("item accepted while step divide runs");

  a_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(div_busy_q) |-> step_q != 17'd0) else $error("cosine step came out zero");

endmodule
`default_nettype wire

// ===== src/kat_back.sv =====
// back end: cosine point sequencer and probability pipeline
`default_nettype none
module kat_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kat_pkg::kat_cfg_t         cfg_i,
  input  kat_pkg::kat_desc_t        desc_i,
  input  logic                      desc_valid_i,
  output logic                      desc_pop_o,
  output logic                      result_valid_o,
  output logic [5:0]                angle_index_o,
  output logic signed [15:0]        cosine_angle_o,
  output logic [kat_pkg::ProbW-1:0] probability_o,
  output logic                      last_point_o
);
  import kat_pkg::*;

  localparam int unsigned SbExp = 1 + ExpLat;
  localparam int unsigned SbN2  = SbExp + 2;
  localparam int unsigned SbN3  = SbExp + 3;
  localparam int unsigned SbOut = SbExp + 4 + DivLat;
  localparam int unsigned SbLen = SbOut + 1;

  logic        act_q;
  logic [6:0]  k_q;
  logic [16:0] acc_q;
  logic [6:0]  rem_q;
  kat_desc_t   cur_q;
  logic        last_now;
  logic [7:0]  rem_sum;
  logic        wrap;
  logic [16:0] acc_d;
  logic [6:0]  rem_d;
  kat_point_t  pt;
  kat_point_t  sb_q [SbLen];

  logic signed [32:0] x_q;
  logic signed [33:0] aq_s;
  logic signed [33:0] t1_full;
  logic signed [33:0] t2_full;
  logic [31:0] t1_q;
  logic [31:0] t2_q;
  logic [31:0] t0_q;
  logic [32:0] e1;
  logic [32:0] e2;
  logic [32:0] e0;

  logic [16:0] rp;
  logic [16:0] rm;
  logic [49:0] m1_q;
  logic [49:0] m2_q;
  logic [32:0] d1_q;
  logic [50:0] nsum;
  logic [32:0] n31_q;
  logic [32:0] d2_q;
  logic [48:0] prod_q;
  logic [32:0] d3_q;
  logic        special;
  logic [52:0] xdiv_q;
  logic [32:0] ddiv_q;
  logic [ProbW-1:0] pq;

  logic             res_vld_q;
  logic [6:0]       res_idx_q;
  logic [15:0]      res_mu_q;
  logic [ProbW-1:0] res_prob_q;
  logic             res_last_q;

  // cosine sequencer: acc accumulates floor(65536 k / n) by step and remainder; mu is acc minus 32768
  assign last_now   = act_q && (k_q == (cfg_i.cnt - 7'd1));
  assign desc_pop_o = desc_valid_i && (!act_q || last_now);

  assign rem_sum = {1'b0, rem_q} + {1'b0, cfg_i.frac};
  assign wrap    = rem_sum >= {1'b0, cfg_i.cnt};
  assign acc_d   = acc_q + cfg_i.step + 17'(wrap);
  assign rem_d   = wrap ? 7'(rem_sum - {1'b0, cfg_i.cnt}) : rem_sum[6:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      k_q   <= '0;
      acc_q <= '0;
      rem_q <= '0;
    end else if (desc_pop_o) begin
      act_q <= 1'b1;
      k_q   <= '0;
      acc_q <= '0;
      rem_q <= '0;
    end else if (last_now) begin
      act_q <= 1'b0;
    end else if (act_q) begin
      k_q   <= k_q + 7'd1;
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (desc_pop_o) begin
      cur_q <= desc_i;
    end
  end

  assign pt.vld      = act_q;
  assign pt.idx      = k_q;
  assign pt.mu       = {~acc_q[15], acc_q[14:0]};
  assign pt.last     = last_now;
  assign pt.slope    = cur_q.slope;
  assign pt.fraction = cur_q.fraction;
  assign pt.zero     = cur_q.zero;

  // point sideband follows the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SbLen; i++) begin
        sb_q[i] <= '0;
      end
    end else begin
      sb_q[0] <= pt;
      for (int i = 1; i < SbLen; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
    end
  end

  // x = a * mu in q27
  always_ff @(posedge clk_i) begin
    x_q <= $signed({1'b0, pt.slope}) * $signed(pt.mu);
  end

  // exponent arguments, all non-negative
  assign aq_s    = $signed({3'b0, sb_q[0].slope, 15'b0});
  assign t1_full = aq_s - $signed({x_q[32], x_q});
  assign t2_full = aq_s + $signed({x_q[32], x_q});

  always_ff @(posedge clk_i) begin
    t1_q <= t1_full[31:0];
    t2_q <= t2_full[31:0];
    t0_q <= {sb_q[0].slope, 16'b0};
  end

  kat_exp u_exp1 (.clk_i(clk_i), .t_i(t1_q), .e_o(e1));
  kat_exp u_exp2 (.clk_i(clk_i), .t_i(t2_q), .e_o(e2));
  kat_exp u_exp0 (.clk_i(clk_i), .t_i(t0_q), .e_o(e0));

  // weighted numerator terms and denominator
  assign rp = {1'b0, HalfQ16} + {1'b0, sb_q[SbExp].fraction};
  assign rm = {1'b0, HalfQ16} - {1'b0, sb_q[SbExp].fraction};

  always_ff @(posedge clk_i) begin
    m1_q <= 50'(rp) * 50'(e1);
    m2_q <= 50'(rm) * 50'(e2);
    d1_q <= OneQ32 - e0;
  end

  assign nsum = {1'b0, m1_q} + {1'b0, m2_q};

  always_ff @(posedge clk_i) begin
    n31_q <= nsum[48:16];
    d2_q  <= d1_q;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 49'(sb_q[SbN2].slope) * 49'(n31_q);
    d3_q   <= d2_q;
  end

  // dividend with rounding; zero slope or zero denominator forced to one half
  assign special = sb_q[SbN3].zero || (d3_q == 33'd0);

  always_ff @(posedge clk_i) begin
    if (special) begin
      xdiv_q <= 53'(HalfQ16);
      ddiv_q <= 33'd1;
    end else begin
      xdiv_q <= {prod_q, 4'b0} + 53'(d3_q >> 1);
      ddiv_q <= d3_q;
    end
  end

  kat_pdiv u_pdiv (.clk_i(clk_i), .x_i(xdiv_q), .d_i(ddiv_q), .q_o(pq));

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= sb_q[SbOut].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_idx_q  <= sb_q[SbOut].idx;
    res_mu_q   <= sb_q[SbOut].mu;
    res_prob_q <= pq;
    res_last_q <= sb_q[SbOut].last && sb_q[SbOut].vld;
  end

  assign result_valid_o = res_vld_q;
  assign angle_index_o  = res_idx_q[5:0];
  assign cosine_angle_o = $signed(res_mu_q);
  assign probability_o  = res_prob_q;
  assign last_point_o   = res_last_q && res_vld_q;

  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_pop_o |-> desc_valid_i) else $error("pop from empty item queue");

  a_next_starts_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_point_o) ##1 result_valid_o |-> angle_index_o == 6'd0)
    else $error("new item did not start at cosine index zero");

  a_seq_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> k_q < cfg_i.cnt) else $error("cosine index ran past the count");

endmodule
`default_nettype wire

// ===== src/kalbach_angular_table.sv =====
// kalbach angular table: per item, emits the angular density at n cosine points
//
// input: present slope_param_i (q4.12) and fraction_param_i (q1.15) with start_i;
// the item transfers at a rising edge with start_i high and busy_o low.
// configuration: sample_count transfers on cfg_data_i when cfg_valid_i and
// cfg_ready_o are high; a write recomputes the cosine step by a serial divide,
// during which busy_o and not cfg_ready_o are shown.
// output: each point appears for one cycle with result_valid_o, carrying
// angle_index_o, cosine_angle_o, probability_o and last_point_o on the final
// point; the receiver cannot hold results off.
// throughput: one point per cycle; a two-entry item queue lets following
// items transfer while earlier ones are computed. each point passes the
// three exponential pipelines (26 stages) and the bit-per-stage output
// divider (22 stages).
// reset: sample_count returns to 32, queue and pipeline are emptied.
`default_nettype none
module kalbach_angular_table #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [15:0]               slope_param_i,
  input  logic [15:0]               fraction_param_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [6:0]                cfg_data_i,
  output logic                      result_valid_o,
  output logic [5:0]                angle_index_o,
  output logic signed [15:0]        cosine_angle_o,
  output logic [kat_pkg::ProbW-1:0] probability_o,
  output logic                      last_point_o
);
  import kat_pkg::*;

  kat_cfg_t  cfg;
  kat_desc_t desc;
  logic      desc_valid;
  logic      desc_pop;

  // front: config, accept, classify, queue
  kat_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .slope_param_i   (slope_param_i),
    .fraction_param_i(fraction_param_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .cfg_o           (cfg),
    .desc_o          (desc),
    .desc_valid_o    (desc_valid),
    .desc_pop_i      (desc_pop)
  );

  // back: sequencer and probability pipeline
  kat_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .desc_i        (desc),
    .desc_valid_i  (desc_valid),
    .desc_pop_o    (desc_pop),
    .result_valid_o(result_valid_o),
    .angle_index_o (angle_index_o),
    .cosine_angle_o(cosine_angle_o),
    .probability_o (probability_o),
    .last_point_o  (last_point_o)
  );

endmodule
`default_nettype wire
